[rtl/erss_pkg.sv]
// Shared constants, codes, types and the exponent table for the eased speed sequencer.
`timescale 1ns / 1ps

package erss_pkg;

    localparam int FRAC_BITS = 16;
    localparam int MAX_FRAC  = 24;
    localparam int EXP_FRAC  = 30;

    localparam int ROT_W   = 19;
    localparam int WAIT_W  = 20;
    localparam int GEAR_W  = 13;
    localparam int MINSP_W = 10;
    localparam int EASE_W  = 4;
    localparam int KIND_W  = 2;
    localparam int TICK_W  = 10;
    localparam int SPEED_W = 22;
    localparam int PHASE_W = 2;
    localparam int ELAP_W  = 20;
    localparam int BASE_W  = 28;
    localparam int BNUM_W  = 36;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam logic [ELAP_W-1:0]  ELAPSED_MAX = 20'hFFFFF;
    localparam logic [SPEED_W-1:0] SPEED_MAX   = 22'd4000000;
    localparam logic [31:0]        BASE_NUM    = 32'd6000000;
    localparam logic [EASE_W-1:0]  EASE_MIN    = 4'd1;
    localparam logic [EASE_W-1:0]  EASE_MAX    = 4'd10;

    localparam logic [ROT_W-1:0]   ROT_RST   = 19'd10000;
    localparam logic [WAIT_W-1:0]  WAIT_RST  = 20'd30000;
    localparam logic [GEAR_W-1:0]  GEAR_RST  = 13'd819;
    localparam logic [MINSP_W-1:0] MINSP_RST = 10'd10;
    localparam logic [EASE_W-1:0]  EASE_RST  = 4'd10;

    localparam logic [2:0] REG_ROT   = 3'd0;
    localparam logic [2:0] REG_WAIT  = 3'd1;
    localparam logic [2:0] REG_GEAR  = 3'd2;
    localparam logic [2:0] REG_MINSP = 3'd3;
    localparam logic [2:0] REG_EASE  = 3'd4;

    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GO    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ABORT = 2'd2;

    localparam logic [PHASE_W-1:0] PH_REV  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_WAIT = 2'd1;
    localparam logic [PHASE_W-1:0] PH_STOP = 2'd2;

    typedef logic [31:0] t_ctab [0:MAX_FRAC];

    function automatic t_ctab exp_table();
        t_ctab       tab;
        logic [63:0] c;
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        int          i;
        c = 64'd2 << EXP_FRAC;
        tab[0] = c[31:0];
        for (i = 1; i <= MAX_FRAC; i++) begin
            x = c << EXP_FRAC;
            r = 64'd0;
            b = 64'd1 << 62;
            while (b > x) b = b >> 2;
            while (b != 64'd0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            c = r;
            tab[i] = c[31:0];
        end
        return tab;
    endfunction

endpackage

[rtl/eased_revolution_speed_sequencer_top.sv]
// Top level of the eased revolution speed sequencer.
// Use: the input channel (i_in_valid, o_in_stall) carries one transaction per item:
// i_kind is a tick, go or abort, i_tick_ms the milliseconds since the last tick.
// Each item gives exactly one output transaction (o_out_valid, i_out_stall) with the
// speed command o_speed in 0.01 rpm and the phase o_phase_out after the item.
// The user writes registers through the APB port only while the block is idle;
// the block itself does not enforce this. Go, abort, and ticks that compute no
// speed pass from acceptance straight to the output state, which raises the output
// valid once the output register is free. A tick inside a revolution computes the
// eased speed with one shared multiplier and one bit-serial divider under a
// sequencer: base product and division, progress division and velocity square;
// then, if the velocity is not zero, normalization, logarithm, division by the
// easing level and exponent for levels above one, and last the scale and clamp.
// One item is in work at a time: o_in_stall is high until its result is loaded.
// A finished result waits in the output register while the receiver stalls; the
// next item is accepted meanwhile and its result is held until the register frees.
// Synchronous reset sets the phase to waiting, clears elapsed time and last speed,
// loads the register defaults and empties the output register.
`timescale 1ns / 1ps

module eased_revolution_speed_sequencer_top #(
    parameter int P_FRAC_BITS = erss_pkg::FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [erss_pkg::KIND_W-1:0]   i_kind,
    input  logic [erss_pkg::TICK_W-1:0]   i_tick_ms,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [erss_pkg::SPEED_W-1:0]  o_speed,
    output logic [erss_pkg::PHASE_W-1:0]  o_phase_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [erss_pkg::ADDR_W-1:0]   paddr,
    input  logic [erss_pkg::DATA_W-1:0]   pwdata,
    output logic [erss_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int F     = P_FRAC_BITS;
    localparam int LW    = F + 7;
    localparam int NW    = (erss_pkg::BNUM_W > erss_pkg::ELAP_W + F) ?
                           erss_pkg::BNUM_W : erss_pkg::ELAP_W + F;
    localparam int DW    = erss_pkg::ROT_W + 8;
    localparam int SH_W  = $clog2(F + 2);
    localparam int CNT_W = $clog2(F + 1);
    localparam int SV_W  = erss_pkg::BASE_W + 2;
    localparam erss_pkg::t_ctab C_TAB = erss_pkg::exp_table();

    typedef enum logic [15:0] {
        S_IDLE  = 16'b0000_0000_0000_0001,
        S_BMUL  = 16'b0000_0000_0000_0010,
        S_BDIV  = 16'b0000_0000_0000_0100,
        S_BWAIT = 16'b0000_0000_0000_1000,
        S_PDIV  = 16'b0000_0000_0001_0000,
        S_PWAIT = 16'b0000_0000_0010_0000,
        S_VMUL  = 16'b0000_0000_0100_0000,
        S_NORM  = 16'b0000_0000_1000_0000,
        S_LOG   = 16'b0000_0001_0000_0000,
        S_LPREP = 16'b0000_0010_0000_0000,
        S_LDIV  = 16'b0000_0100_0000_0000,
        S_LWAIT = 16'b0000_1000_0000_0000,
        S_EXP   = 16'b0001_0000_0000_0000,
        S_SCALE = 16'b0010_0000_0000_0000,
        S_CLAMP = 16'b0100_0000_0000_0000,
        S_OUT   = 16'b1000_0000_0000_0000
    } t_state;

    t_state                          r_state;
    logic [erss_pkg::ROT_W-1:0]      r_rot;
    logic [erss_pkg::WAIT_W-1:0]     r_wait;
    logic [erss_pkg::GEAR_W-1:0]     r_gear;
    logic [erss_pkg::MINSP_W-1:0]    r_minsp;
    logic [erss_pkg::EASE_W-1:0]     r_ease;
    logic [erss_pkg::PHASE_W-1:0]    r_phase;
    logic [erss_pkg::ELAP_W-1:0]     r_elapsed;
    logic [erss_pkg::SPEED_W-1:0]    r_last;
    logic [erss_pkg::SPEED_W-1:0]    r_res;
    logic                            r_out_valid;
    logic [erss_pkg::SPEED_W-1:0]    r_out_speed;
    logic [erss_pkg::PHASE_W-1:0]    r_out_phase;

    logic [erss_pkg::BASE_W-1:0]     r_base;
    logic [F-1:0]                    r_q;
    logic [F+1:0]                    r_x;
    logic [SH_W-1:0]                 r_shift;
    logic [F:0]                      r_m;
    logic [F-1:0]                    r_fr;
    logic [CNT_W-1:0]                r_cnt;
    logic                            r_neg;
    logic [LW-1:0]                   r_mag;
    logic [F-1:0]                    r_f;
    logic [5:0]                      r_rsh;
    logic [30:0]                     r_acc;
    logic [F+1:0]                    r_root;
    logic [63:0]                     r_prod;

    logic [31:0]                     mul_a;
    logic [31:0]                     mul_b;
    logic [63:0]                     mul_p;
    logic [63:0]                     v12;
    logic [F+1:0]                    v_next;
    logic [F+1:0]                    sq;
    logic [erss_pkg::EASE_W-1:0]     ease_k;
    logic [erss_pkg::ELAP_W:0]       el_sum;
    logic [erss_pkg::ELAP_W-1:0]     el_new;
    logic                            div_start;
    logic [NW-1:0]                   div_num;
    logic [DW-1:0]                   div_den;
    logic                            div_done;
    logic [NW-1:0]                   div_quot;
    logic [F-1:0]                    p_val;
    logic signed [LW-1:0]            lg;
    logic signed [LW-1:0]            y_val;
    logic signed [7:0]               n_val;
    logic signed [7:0]               sh_val;
    logic [30:0]                     acc_next;
    logic [SV_W-1:0]                 sv;
    logic                            in_acc;
    logic                            out_free;
    logic                            cfg_wr;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign cfg_wr     = psel && penable && pwrite;
    assign pready     = 1'b1;

    assign ease_k = (r_ease < erss_pkg::EASE_MIN) ? erss_pkg::EASE_MIN :
                    (r_ease > erss_pkg::EASE_MAX) ? erss_pkg::EASE_MAX : r_ease;

    assign el_sum = {1'b0, r_elapsed} + (erss_pkg::ELAP_W + 1)'(i_tick_ms);
    assign el_new = el_sum[erss_pkg::ELAP_W] ? erss_pkg::ELAPSED_MAX
                                              : el_sum[erss_pkg::ELAP_W-1:0];

    always_comb begin
        unique case (r_state)
            S_BMUL: begin
                mul_a = erss_pkg::BASE_NUM;
                mul_b = 32'(r_gear);
            end
            S_VMUL: begin
                mul_a = 32'(r_q);
                mul_b = 32'(r_q);
            end
            S_LOG: begin
                mul_a = 32'(r_m);
                mul_b = 32'(r_m);
            end
            S_EXP: begin
                mul_a = 32'(r_acc);
                mul_b = C_TAB[r_cnt];
            end
            S_SCALE: begin
                mul_a = 32'(r_base);
                mul_b = 32'(r_root);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign v12      = (mul_p << 3) + (mul_p << 2);
    assign v_next   = v12[2*F+1:F];
    assign sq       = mul_p[2*F+1:F];
    assign acc_next = r_f[F-1] ? mul_p[60:30] : r_acc;
    assign p_val    = div_quot[F-1:0];
    assign sv       = r_prod[F+SV_W-1:F];

    assign lg     = ((LW'(1) - LW'(r_shift)) <<< F) + LW'(r_fr);
    assign y_val  = r_neg ? -signed'(div_quot[LW-1:0]) : signed'(div_quot[LW-1:0]);
    assign n_val  = 8'(y_val >>> F);
    assign sh_val = 8'(erss_pkg::EXP_FRAC - F) - n_val;

    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        unique case (r_state)
            S_BDIV: begin
                div_start = 1'b1;
                div_num   = NW'(r_prod[erss_pkg::BNUM_W-1:0]);
                div_den   = {r_rot, 8'd0};
            end
            S_PDIV: begin
                div_start = 1'b1;
                div_num   = NW'({r_elapsed, {F{1'b0}}});
                div_den   = DW'(r_rot);
            end
            S_LDIV: begin
                div_start = 1'b1;
                div_num   = NW'(r_mag);
                div_den   = DW'(ease_k);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    erss_div #(
        .NW (NW),
        .DW (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot   <= erss_pkg::ROT_RST;
            r_wait  <= erss_pkg::WAIT_RST;
            r_gear  <= erss_pkg::GEAR_RST;
            r_minsp <= erss_pkg::MINSP_RST;
            r_ease  <= erss_pkg::EASE_RST;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                erss_pkg::REG_ROT:   r_rot   <= pwdata[erss_pkg::ROT_W-1:0];
                erss_pkg::REG_WAIT:  r_wait  <= pwdata[erss_pkg::WAIT_W-1:0];
                erss_pkg::REG_GEAR:  r_gear  <= pwdata[erss_pkg::GEAR_W-1:0];
                erss_pkg::REG_MINSP: r_minsp <= pwdata[erss_pkg::MINSP_W-1:0];
                erss_pkg::REG_EASE:  r_ease  <= pwdata[erss_pkg::EASE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            erss_pkg::REG_ROT:   prdata = 32'(r_rot);
            erss_pkg::REG_WAIT:  prdata = 32'(r_wait);
            erss_pkg::REG_GEAR:  prdata = 32'(r_gear);
            erss_pkg::REG_MINSP: prdata = 32'(r_minsp);
            erss_pkg::REG_EASE:  prdata = 32'(r_ease);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= erss_pkg::PH_WAIT;
            r_elapsed   <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        priority if (i_kind == erss_pkg::KIND_TICK) begin
                            r_res <= '0;
                            r_last <= '0;
                            priority if (r_phase == erss_pkg::PH_REV) begin
                                if (el_new >= erss_pkg::ELAP_W'(r_rot)) begin
                                    r_phase   <= erss_pkg::PH_WAIT;
                                    r_elapsed <= '0;
                                    r_state   <= S_OUT;
                                end else begin
                                    r_elapsed <= el_new;
                                    r_state   <= S_BMUL;
                                end
                            end else if (r_phase == erss_pkg::PH_WAIT) begin
                                r_state <= S_OUT;
                                if (el_new >= r_wait) begin
                                    r_phase   <= erss_pkg::PH_REV;
                                    r_elapsed <= '0;
                                end else begin
                                    r_elapsed <= el_new;
                                end
                            end else begin
                                r_elapsed <= el_new;
                                r_state   <= S_OUT;
                            end
                        end else if (i_kind == erss_pkg::KIND_GO) begin
                            r_phase   <= erss_pkg::PH_REV;
                            r_elapsed <= '0;
                            r_res     <= r_last;
                            r_state   <= S_OUT;
                        end else if (i_kind == erss_pkg::KIND_ABORT) begin
                            r_phase <= erss_pkg::PH_STOP;
                            r_res   <= '0;
                            r_last  <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_res   <= r_last;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_BMUL: begin
                    r_prod  <= mul_p;
                    r_state <= S_BDIV;
                end
                S_BDIV: begin
                    r_state <= S_BWAIT;
                end
                S_BWAIT: begin
                    if (div_done) begin
                        r_base  <= div_quot[erss_pkg::BASE_W-1:0];
                        r_state <= S_PDIV;
                    end
                end
                S_PDIV: begin
                    r_state <= S_PWAIT;
                end
                S_PWAIT: begin
                    if (div_done) begin
                        r_q     <= p_val[F-1] ? -p_val : p_val;
                        r_state <= S_VMUL;
                    end
                end
                S_VMUL: begin
                    r_x     <= v_next;
                    r_root  <= v_next;
                    r_shift <= '0;
                    priority if (v_next == '0) begin
                        r_res   <= '0;
                        r_last  <= '0;
                        r_state <= S_OUT;
                    end else if (ease_k == erss_pkg::EASE_MIN) begin
                        r_state <= S_SCALE;
                    end else begin
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    if (!r_x[F+1]) begin
                        r_x     <= r_x << 1;
                        r_shift <= r_shift + SH_W'(1);
                    end else begin
                        r_m     <= r_x[F+1:1];
                        r_cnt   <= '0;
                        r_state <= S_LOG;
                    end
                end
                S_LOG: begin
                    if (sq[F+1]) begin
                        r_m  <= sq[F+1:1];
                        r_fr <= {r_fr[F-2:0], 1'b1};
                    end else begin
                        r_m  <= sq[F:0];
                        r_fr <= {r_fr[F-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(F - 1)) begin
                        r_state <= S_LPREP;
                    end
                end
                S_LPREP: begin
                    r_neg   <= lg[LW-1];
                    r_mag   <= lg[LW-1] ? LW'(-lg + LW'(ease_k) - LW'(1)) : LW'(lg);
                    r_state <= S_LDIV;
                end
                S_LDIV: begin
                    r_state <= S_LWAIT;
                end
                S_LWAIT: begin
                    if (div_done) begin
                        r_f     <= y_val[F-1:0];
                        r_rsh   <= sh_val[5:0];
                        r_acc   <= 31'(1) << erss_pkg::EXP_FRAC;
                        r_cnt   <= CNT_W'(1);
                        r_state <= S_EXP;
                    end
                end
                S_EXP: begin
                    r_acc <= acc_next;
                    r_f   <= r_f << 1;
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(F)) begin
                        r_root  <= (F + 2)'(acc_next >> r_rsh);
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    r_prod  <= mul_p;
                    r_state <= S_CLAMP;
                end
                S_CLAMP: begin
                    priority if (sv != '0 && sv < SV_W'(r_minsp)) begin
                        r_res  <= erss_pkg::SPEED_W'(r_minsp);
                        r_last <= erss_pkg::SPEED_W'(r_minsp);
                    end else if (sv > SV_W'(erss_pkg::SPEED_MAX)) begin
                        r_res  <= erss_pkg::SPEED_MAX;
                        r_last <= erss_pkg::SPEED_MAX;
                    end else begin
                        r_res  <= sv[erss_pkg::SPEED_W-1:0];
                        r_last <= sv[erss_pkg::SPEED_W-1:0];
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_out_speed <= r_res;
            r_out_phase <= r_phase;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_speed     = r_out_speed;
    assign o_phase_out = r_out_phase;

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != S_IDLE))
        else $error("accepted transaction did not start work");

    a_speed_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_speed <= erss_pkg::SPEED_MAX))
        else $error("speed command above limit");

    a_phase_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == erss_pkg::PH_REV || r_phase == erss_pkg::PH_WAIT ||
         r_phase == erss_pkg::PH_STOP))
        else $error("illegal phase code");

    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_BWAIT || r_state == S_PWAIT || r_state == S_LWAIT))
        else $error("divider finished outside a wait state");

endmodule

[rtl/erss_div.sv]
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module erss_div #(
    parameter int NW = 36,
    parameter int DW = 27
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);

    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_num;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    assign trial = {r_rem, r_num[NW-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
            r_num <= {r_num[NW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

[tb/erss_checker.sv]
// Checker for the eased speed sequencer: predicts each result and compares it.
`timescale 1ns / 1ps

module erss_checker
    import erss_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [KIND_W-1:0]    i_kind,
    input  logic [TICK_W-1:0]    i_tick_ms,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [SPEED_W-1:0]   i_speed,
    input  logic [PHASE_W-1:0]   i_phase_out,
    input  logic                 i_psel,
    input  logic                 i_penable,
    input  logic                 i_pwrite,
    input  logic                 i_pready,
    input  logic [ADDR_W-1:0]    i_paddr,
    input  logic [DATA_W-1:0]    i_pwdata,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_result_count,
    output int                   o_moving_count
);

    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic [PHASE_W-1:0] phase;
    } t_cmd;

    t_cmd                expected_cmds[$];
    logic [ROT_W-1:0]    rot_ms;
    logic [WAIT_W-1:0]   wait_ms;
    logic [GEAR_W-1:0]   gear;
    logic [MINSP_W-1:0]  min_sp;
    logic [EASE_W-1:0]   ease;
    logic [PHASE_W-1:0]  cur_phase;
    logic [ELAP_W-1:0]   elapsed;
    logic [SPEED_W-1:0]  last_sp;
    logic [63:0]         pow_tab [1:FRAC_BITS];

    function automatic logic [63:0] isqrt64(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    initial begin
        logic [63:0] c;
        c = 64'd2 << EXP_FRAC;
        for (int i = 1; i <= FRAC_BITS; i++) begin
            c = isqrt64(c << EXP_FRAC);
            pow_tab[i] = c;
        end
    end

    function automatic logic [63:0] kth_root(logic [63:0] v, int k);
        int          msb;
        int          n;
        logic [63:0] m;
        logic [63:0] fr;
        logic [63:0] yb;
        logic [63:0] acc;
        longint      lg;
        longint      y;
        if (v == 0) return 0;
        if (k <= 1) return v;
        msb = 0;
        for (int i = 1; i < 64; i++) if (v[i]) msb = i;
        m = (msb >= FRAC_BITS) ? (v >> (msb - FRAC_BITS)) : (v << (FRAC_BITS - msb));
        fr = 0;
        for (int i = 0; i < FRAC_BITS; i++) begin
            m = (m * m) >> FRAC_BITS;
            fr = fr << 1;
            if (m >= (64'd2 << FRAC_BITS)) begin
                m = m >> 1;
                fr[0] = 1'b1;
            end
        end
        lg = longint'(msb - FRAC_BITS) * (longint'(1) << FRAC_BITS) + longint'(fr);
        if (lg >= 0) y = lg / k;
        else y = -((-lg + k - 1) / k);
        yb = 64'(y + 64 * (longint'(1) << FRAC_BITS));
        n = int'(yb >> FRAC_BITS) - 64;
        acc = 64'd1 << EXP_FRAC;
        for (int i = 1; i <= FRAC_BITS; i++)
            if (yb[FRAC_BITS-i]) acc = (acc * pow_tab[i]) >> EXP_FRAC;
        return acc >> (EXP_FRAC - FRAC_BITS - n);
    endfunction

    function automatic logic [SPEED_W-1:0] eased_cmd();
        logic [63:0] base;
        logic [63:0] prog;
        logic [63:0] q;
        logic [63:0] vel;
        logic [63:0] s;
        int          k;
        k = ease;
        if (k < 1) k = 1;
        if (k > 10) k = 10;
        base = (64'd6000000 * gear) / (64'd256 * rot_ms);
        prog = (64'(elapsed) << FRAC_BITS) / rot_ms;
        q = (prog < (64'd1 << (FRAC_BITS - 1))) ? prog : ((64'd1 << FRAC_BITS) - prog);
        vel = (64'd12 * q * q) >> FRAC_BITS;
        s = (base * kth_root(vel, k)) >> FRAC_BITS;
        if (s > 0 && s < min_sp) s = min_sp;
        if (s > SPEED_MAX) s = SPEED_MAX;
        return s[SPEED_W-1:0];
    endfunction

    function automatic t_cmd advance(logic [KIND_W-1:0] kind, logic [TICK_W-1:0] tick);
        logic [20:0]        sum;
        logic [SPEED_W-1:0] sp;
        sp = last_sp;
        if (kind == KIND_TICK) begin
            sum = elapsed + tick;
            elapsed = (sum > ELAPSED_MAX) ? ELAPSED_MAX : sum[ELAP_W-1:0];
            if (cur_phase == PH_REV) begin
                if (elapsed >= rot_ms) begin
                    sp = 0;
                    cur_phase = PH_WAIT;
                    elapsed = 0;
                end else begin
                    sp = eased_cmd();
                end
            end else if (cur_phase == PH_WAIT) begin
                sp = 0;
                if (elapsed >= wait_ms) begin
                    cur_phase = PH_REV;
                    elapsed = 0;
                end
            end else begin
                sp = 0;
            end
        end else if (kind == KIND_GO) begin
            cur_phase = PH_REV;
            elapsed = 0;
        end else if (kind == KIND_ABORT) begin
            cur_phase = PH_STOP;
            sp = 0;
        end
        last_sp = sp;
        return '{speed: sp, phase: cur_phase};
    endfunction

    always @(posedge i_clk) begin
        t_cmd want;
        int   fails;
        fails = 0;
        if (!i_rst_n) begin
            rot_ms = ROT_RST;
            wait_ms = WAIT_RST;
            gear = GEAR_RST;
            min_sp = MINSP_RST;
            ease = EASE_RST;
            cur_phase = PH_WAIT;
            elapsed = '0;
            last_sp = '0;
            expected_cmds.delete();
            o_fail_count <= 0;
            o_result_count <= 0;
            o_moving_count <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[ADDR_W-1:2])
                    REG_ROT:   rot_ms  = i_pwdata[ROT_W-1:0];
                    REG_WAIT:  wait_ms = i_pwdata[WAIT_W-1:0];
                    REG_GEAR:  gear    = i_pwdata[GEAR_W-1:0];
                    REG_MINSP: min_sp  = i_pwdata[MINSP_W-1:0];
                    REG_EASE:  ease    = i_pwdata[EASE_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                expected_cmds.push_back(advance(i_kind, i_tick_ms));
            if (i_out_valid && !i_out_stall) begin
                o_result_count <= o_result_count + 1;
                if (i_speed != 0) o_moving_count <= o_moving_count + 1;
                if (expected_cmds.size() == 0) begin
                    $error("unexpected transaction: speed %0d phase %0d",
                           i_speed, i_phase_out);
                    fails = fails + 1;
                end else begin
                    want = expected_cmds.pop_front();
                    if (want.speed !== i_speed) begin
                        $error("speed: expected %0d, actual %0d", want.speed, i_speed);
                        fails = fails + 1;
                    end
                    if (want.phase !== i_phase_out) begin
                        $error("phase_out: expected %0d, actual %0d",
                               want.phase, i_phase_out);
                        fails = fails + 1;
                    end
                end
            end
            o_fail_count <= o_fail_count + fails;
        end
        o_pending <= expected_cmds.size();
    end

endmodule

[tb/eased_revolution_speed_sequencer_top_tb.sv]
// Testbench top for the eased speed sequencer: stimulus, register writes and verdict.
`timescale 1ns / 1ps

module eased_revolution_speed_sequencer_top_tb;
    import erss_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [KIND_W-1:0]   i_kind;
    logic [TICK_W-1:0]   i_tick_ms;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [SPEED_W-1:0]  o_speed;
    logic [PHASE_W-1:0]  o_phase_out;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    int                  fail_count;
    int                  pending;
    int                  result_count;
    int                  moving_count;
    int                  cycles;
    bit                  quiet;
    bit                  hold_req;

    eased_revolution_speed_sequencer_top dut (.*);

    erss_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall),
        .i_kind(i_kind), .i_tick_ms(i_tick_ms),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .i_speed(o_speed), .i_phase_out(o_phase_out),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_result_count(result_count), .o_moving_count(moving_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("** eased_revolution_speed_sequencer_top: FAILED **");
            $finish;
        end
    end

    always begin
        if (hold_req) begin
            i_out_stall <= 1'b1;
            repeat (400) @(posedge i_clk);
            hold_req = 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end else begin
            i_out_stall <= 1'b0;
            @(posedge i_clk);
        end
    end

    task automatic send_cmd(logic [KIND_W-1:0] kind, logic [TICK_W-1:0] tick);
        i_in_valid <= 1'b1;
        i_kind <= kind;
        i_tick_ms <= tick;
        do @(posedge i_clk); while (o_in_stall);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    task automatic reg_write(logic [2:0] idx, logic [DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(idx) << 2;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic set_profile(int rot, int wt, int gr, int ms, int ez);
        drain();
        reg_write(REG_ROT, rot);
        reg_write(REG_WAIT, wt);
        reg_write(REG_GEAR, gr);
        reg_write(REG_MINSP, ms);
        reg_write(REG_EASE, ez);
    endtask

    task automatic random_cmds(int count, int max_tick);
        int sel;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 85) send_cmd(KIND_TICK, TICK_W'($urandom_range(0, max_tick)));
            else if (sel < 93) send_cmd(KIND_GO, TICK_W'($urandom));
            else if (sel < 98) send_cmd(KIND_ABORT, TICK_W'($urandom));
            else send_cmd(KIND_UNUSED, TICK_W'($urandom));
        end
    endtask

    initial begin
        cycles = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_kind <= KIND_TICK;
        i_tick_ms <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset profile, boundary ticks, every command kind.
        send_cmd(KIND_TICK, 10'd0);
        send_cmd(KIND_GO, 10'd0);
        send_cmd(KIND_TICK, 10'd1000);
        send_cmd(KIND_TICK, 10'd1023);
        send_cmd(KIND_UNUSED, 10'd5);
        send_cmd(KIND_ABORT, 10'd0);
        send_cmd(KIND_TICK, 10'd1000);
        send_cmd(KIND_GO, 10'd0);
        for (int i = 0; i < 6; i++) send_cmd(KIND_TICK, 10'd999);

        // Zero revolution length, no wait, easing level out of range low.
        set_profile(0, 0, 8191, 1023, 0);
        send_cmd(KIND_GO, 10'd0);
        send_cmd(KIND_TICK, 10'd0);
        send_cmd(KIND_TICK, 10'd0);
        send_cmd(KIND_TICK, 10'd1);

        // Short revolution, strongest gear, easing level out of range high.
        set_profile(100, 0, 8191, 0, 15);
        send_cmd(KIND_GO, 10'd0);
        for (int i = 0; i < 6; i++) send_cmd(KIND_TICK, 10'd17);

        // Long revolution and wait, weak gear, level one.
        set_profile(300000, 600000, 26, 1000, 1);
        send_cmd(KIND_GO, 10'd0);
        for (int i = 0; i < 4; i++) send_cmd(KIND_TICK, 10'd1000);

        // Random phases across several profiles.
        set_profile(1500, 300, 819, 10, 10);
        random_cmds(130, 1000);
        set_profile($urandom_range(100, 3000), $urandom_range(0, 2000),
                    $urandom_range(26, 5120), $urandom_range(0, 1000), $urandom_range(1, 10));
        hold_req = 1'b1;
        random_cmds(130, 1000);
        set_profile(100, 0, 5120, 1000, 2);
        random_cmds(120, 60);
        set_profile($urandom_range(0, 524287), $urandom_range(0, 1048575),
                    $urandom_range(0, 8191), $urandom_range(0, 1023), $urandom_range(0, 15));
        random_cmds(100, 1023);
        set_profile($urandom_range(200, 4000), $urandom_range(0, 1500),
                    $urandom_range(26, 5120), $urandom_range(0, 1000), $urandom_range(1, 10));
        quiet = 1'b1;
        random_cmds(130, 1000);

        drain();
        repeat (20) @(posedge i_clk);
        $display("Run covered %0d results over several register profiles, %0d with motion.",
                 result_count, moving_count);
        $display("Go, abort, unused kinds, stalls and a long output hold were exercised.");
        if (fail_count == 0) begin
            $display("** eased_revolution_speed_sequencer_top: PASSED **");
        end else begin
            $display("** eased_revolution_speed_sequencer_top: FAILED **");
        end
        $finish;
    end

endmodule
